FILE: hdl/sorted_multiset_insert_delete_assert.svh
// Assertion macros for the sorted multiset store.
`ifndef SORTED_MULTISET_INSERT_DELETE_ASSERT_SVH
`define SORTED_MULTISET_INSERT_DELETE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define SMID_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked out of reset.
`define SMID_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SMID_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SMID_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/smid_pkg.sv
package smid_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_OUT_W = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	// Per-cycle command broadcast to every cell
	typedef enum logic [1:0] {
		CM_HOLD   = 2'b00,
		CM_INSERT = 2'b01,
		CM_DELETE = 2'b10
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t          mode;
		logic [VALUE_W-1:0]  operand;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_DONE = 3'b100
	} smid_state_t;

endpackage

FILE: hdl/smid_cell.sv
module smid_cell import smid_pkg::*; (
	input  logic                       clk,
	input  cell_cmd_t                  cmd,
	input  logic                       in_use,
	input  logic                       left_ge,
	input  logic signed [VALUE_W-1:0]  left_data,
	input  logic signed [VALUE_W-1:0]  right_data,
	output logic signed [VALUE_W-1:0]  data_q,
	output logic                       ge,
	output logic                       eq
);

	// Unused slots count as "greater or equal" so the insert point lands at the tail.
	assign ge = !in_use || (data_q >= $signed(cmd.operand));
	assign eq = in_use && (data_q == $signed(cmd.operand));

	always_ff @(posedge clk) begin
		unique case (cmd.mode)
			CM_INSERT: begin
				// first cell at or past the insert point takes the operand, later cells shift up
				if (left_ge) begin
					data_q <= left_data;
				end else if (ge) begin
					data_q <= $signed(cmd.operand);
				end
			end
			CM_DELETE: begin
				// close one gap: every cell from the first equal entry pulls from the right
				if (ge) begin
					data_q <= right_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule

FILE: hdl/sorted_multiset_insert_delete.sv
// Channel | Handshake          | Payload
// --------+--------------------+----------------------------------------------------
// in      | in_valid/in_stall  | opcode, operand_value
// out     | out_valid/out_stall| entry_count, smallest_value, store_empty,
//         |                    | removed_count, insert_dropped
//
// An insert is accepted, then the cell row shifts unless the store is full.
// A delete removes every entry equal to the operand: the row closes
// one gap per cycle. The next item is accepted in the cycle the result is loaded.
// Reset clears the fill count and handshake state; entry contents are not reset.
// A stalled result holds in the output register; the next item waits behind it.

`include "sorted_multiset_insert_delete_assert.svh"

module sorted_multiset_insert_delete import smid_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic signed [VALUE_W-1:0]       operand_value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [COUNT_OUT_W-1:0]          entry_count,
	output logic signed [VALUE_W-1:0]       smallest_value,
	output logic                            store_empty,
	output logic [COUNT_OUT_W-1:0]          removed_count,
	output logic                            insert_dropped
);

	localparam int CW = $clog2(CAPACITY + 1);

	smid_state_t                 state_q;
	logic                        op_q;
	logic signed [VALUE_W-1:0]   val_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               removed_q;
	logic                        dropped_q;

	logic                        out_valid_q;
	logic [COUNT_OUT_W-1:0]      out_count_q;
	logic signed [VALUE_W-1:0]   out_head_q;
	logic                        out_empty_q;
	logic [COUNT_OUT_W-1:0]      out_removed_q;
	logic                        out_dropped_q;

	cell_cmd_t                   cmd;
	logic signed [VALUE_W-1:0]   cell_data [CAPACITY];
	logic [CAPACITY-1:0]         ge_vec;
	logic [CAPACITY-1:0]         eq_vec;
	logic                        any_eq;
	logic                        full;
	logic                        out_free;
	logic                        load_out;
	logic                        accept;

	assign any_eq   = |eq_vec;
	assign full     = (count_q == CW'(CAPACITY));
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = (state_q == ST_DONE) && out_free;
	// Take a new item when idle, or when the finished result moves out this cycle
	assign in_stall = !((state_q == ST_IDLE) || load_out);
	assign accept   = in_valid && !in_stall;

	// Broadcast command to the cell row
	always_comb begin
		cmd.operand = val_q;
		cmd.mode    = CM_HOLD;
		if (state_q == ST_EXEC) begin
			if (op_q == OP_INSERT) begin
				if (!full) begin
					cmd.mode = CM_INSERT;
				end
			end else if (any_eq) begin
				cmd.mode = CM_DELETE;
			end
		end
	end

	// Row of cells, each holding one entry and trading with its neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                       in_use;
		logic                       left_ge;
		logic signed [VALUE_W-1:0]  left_data;
		logic signed [VALUE_W-1:0]  right_data;

		assign in_use = (CW'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_ge   = 1'b0;
			assign left_data = '0;
		end else begin : g_body
			assign left_ge   = ge_vec[i-1];
			assign left_data = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_data = cell_data[i];
		end else begin : g_inner
			assign right_data = cell_data[i+1];
		end

		smid_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.in_use     (in_use),
			.left_ge    (left_ge),
			.left_data  (left_data),
			.right_data (right_data),
			.data_q     (cell_data[i]),
			.ge         (ge_vec[i]),
			.eq         (eq_vec[i])
		);
	end

	// Control sequencer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			removed_q <= '0;
			dropped_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_EXEC;
						removed_q <= '0;
						dropped_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					if (op_q == OP_INSERT) begin
						// full store: drop the insert and flag it
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_DONE;
					end else if (any_eq) begin
						// remove one equal entry, stay until none remain
						count_q   <= count_q - 1'b1;
						removed_q <= removed_q + 1'b1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (accept) begin
						state_q   <= ST_EXEC;
						removed_q <= '0;
						dropped_q <= 1'b0;
					end else if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			val_q <= operand_value;
		end
	end

	// Output register: hold a stalled result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_count_q   <= COUNT_OUT_W'(count_q);
			out_head_q    <= (count_q == '0) ? '0 : cell_data[0];
			out_empty_q   <= (count_q == '0);
			out_removed_q <= COUNT_OUT_W'(removed_q);
			out_dropped_q <= dropped_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign entry_count    = out_count_q;
	assign smallest_value = out_head_q;
	assign store_empty    = out_empty_q;
	assign removed_count  = out_removed_q;
	assign insert_dropped = out_dropped_q;

	// Fill count never passes the capacity
	`SMID_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY), "count above capacity")
	// Each delete step removes exactly one entry
	`SMID_ASSERT_NXT(a_delete_step, clk, arst_n, (state_q == ST_EXEC) && (op_q == OP_DELETE) && any_eq, count_q == $past(count_q) - 1'b1, "delete step miscounted")
	// Items enter only when the sequencer is free
	`SMID_ASSERT_IMP(a_accept_state, clk, arst_n, accept, (state_q == ST_IDLE) || (state_q == ST_DONE), "item taken while busy")
	// A dropped insert never reports removals
	`SMID_ASSERT_IMP(a_drop_no_removal, clk, arst_n, out_valid && insert_dropped, removed_count == '0, "dropped insert with removals")

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench import smid_pkg::*;;

	localparam int STORE_DEPTH    = 16;
	localparam int RANDOM_ITEMS   = 1700;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;
	// Accepted-item window in which neither side idles.
	localparam int CALM_FIRST     = 700;
	localparam int CALM_LAST      = 1000;

	typedef struct {
		logic                     op;
		logic signed [VALUE_W-1:0] val;
	} store_op_t;

	// Store status after one item, as the block reports it.
	typedef struct {
		logic [COUNT_OUT_W-1:0]    n_entries;
		logic signed [VALUE_W-1:0] head;
		logic                      is_empty;
		logic [COUNT_OUT_W-1:0]    n_removed;
		logic                      dropped;
	} store_status_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      opcode = OP_INSERT;
	logic signed [VALUE_W-1:0] operand_value = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [COUNT_OUT_W-1:0]    entry_count;
	logic signed [VALUE_W-1:0] smallest_value;
	logic                      store_empty;
	logic [COUNT_OUT_W-1:0]    removed_count;
	logic                      insert_dropped;

	store_op_t     pending_ops[$];
	store_status_t expected_status[$];

	// Shadow copy of the sorted store; only entries below shadow_fill are meaningful.
	logic signed [VALUE_W-1:0] shadow_store[STORE_DEPTH];
	int                        shadow_fill = 0;

	int mismatches = 0;
	int items_accepted = 0;
	int quiet_cycles = 0;
	logic calm;

	// Stimulus generator state: current value pool and values queued for insert.
	logic signed [VALUE_W-1:0] value_pool[5];
	int                        pool_size = 1;
	logic signed [VALUE_W-1:0] live_vals[$];

	sorted_multiset_insert_delete #(
		.CAPACITY(STORE_DEPTH)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.operand_value (operand_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.entry_count   (entry_count),
		.smallest_value(smallest_value),
		.store_empty   (store_empty),
		.removed_count (removed_count),
		.insert_dropped(insert_dropped)
	);

	always #4 clk = ~clk;

	assign calm = (items_accepted >= CALM_FIRST) && (items_accepted < CALM_LAST);

	// Apply one item to the shadow store and queue the status the block must return.
	task automatic update_shadow_store(input logic op, input logic signed [VALUE_W-1:0] v);
		store_status_t st;
		int pos;
		int kept;
		int removed;
		removed = 0;
		st.dropped = 1'b0;
		if (op == OP_INSERT) begin
			if (shadow_fill >= STORE_DEPTH) begin
				// Full store: drop the insert, leave contents alone.
				st.dropped = 1'b1;
			end else begin
				// Place before the first entry that is greater than or equal (signed order).
				pos = shadow_fill;
				for (int i = 0; i < shadow_fill; i++) begin
					if (shadow_store[i] >= v) begin
						pos = i;
						break;
					end
				end
				for (int i = shadow_fill; i > pos; i--)
					shadow_store[i] = shadow_store[i-1];
				shadow_store[pos] = v;
				shadow_fill++;
			end
		end else begin
			// Remove every equal entry and close the gaps, keeping order.
			kept = 0;
			for (int i = 0; i < shadow_fill; i++) begin
				if (shadow_store[i] == v) begin
					removed++;
				end else begin
					shadow_store[kept] = shadow_store[i];
					kept++;
				end
			end
			shadow_fill = kept;
		end
		st.n_entries = shadow_fill[COUNT_OUT_W-1:0];
		st.head      = (shadow_fill > 0) ? shadow_store[0] : '0;
		st.is_empty  = (shadow_fill == 0);
		st.n_removed = removed[COUNT_OUT_W-1:0];
		expected_status.push_back(st);
	endtask

	task automatic queue_op(input logic op, input logic signed [VALUE_W-1:0] v);
		store_op_t item;
		bit seen;
		item.op  = op;
		item.val = v;
		pending_ops.push_back(item);
		// Remember inserted values so a later flush can delete them all.
		if (op == OP_INSERT) begin
			seen = 0;
			foreach (live_vals[k])
				if (live_vals[k] == v)
					seen = 1;
			if (!seen)
				live_vals.push_back(v);
		end
	endtask

	// Delete every value inserted so far; leaves the store empty.
	task automatic queue_flush();
		logic signed [VALUE_W-1:0] doomed[$];
		doomed = live_vals;
		live_vals.delete();
		foreach (doomed[k])
			queue_op(OP_DELETE, doomed[k]);
	endtask

	function automatic logic signed [VALUE_W-1:0] extreme_value();
		case ($urandom_range(0, 4))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return '0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	// Mostly pool values so duplicates pile up; some extremes and some wide values.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return value_pool[$urandom_range(0, pool_size - 1)];
		else if (r < 80)
			return extreme_value();
		else
			return $urandom;
	endfunction

	task automatic report_mismatch(input string what, input store_status_t want);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("[%0t] %s: expected cnt=%0d head=%0d empty=%0b rm=%0d drop=%0b",
				$realtime, what, want.n_entries, want.head, want.is_empty,
				want.n_removed, want.dropped);
			$display("[%0t] %s:   actual cnt=%0d head=%0d empty=%0b rm=%0d drop=%0b",
				$realtime, what, entry_count, smallest_value, store_empty,
				removed_count, insert_dropped);
		end
	endtask

	// Input driver: record each accepted item, then advance to the next one or idle.
	always @(posedge clk) begin
		store_op_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				update_shadow_store(opcode, operand_value);
				items_accepted <= items_accepted + 1;
			end
			// A stalled item holds its payload; only move on when it is taken or absent.
			if (!in_valid || !in_stall) begin
				if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= 13)) begin
					item = pending_ops.pop_front();
					in_valid      <= 1'b1;
					opcode        <= item.op;
					operand_value <= item.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: stall at random, check every accepted result against the oldest
	// expectation.
	always @(posedge clk) begin
		store_status_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_status.size() == 0) begin
				want = '{default: '0};
				report_mismatch("unexpected result", want);
			end else begin
				want = expected_status.pop_front();
				if (entry_count !== want.n_entries || smallest_value !== want.head ||
						store_empty !== want.is_empty || removed_count !== want.n_removed ||
						insert_dropped !== want.dropped)
					report_mismatch("result mismatch", want);
			end
		end
		out_stall <= !calm && ($urandom_range(0, 99) < 13);
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int mode;
		int target;

		// Directed: delete on an empty store.
		queue_op(OP_DELETE, 32'sd42);
		// Extremes of the value range, including all-ones and all-zeros patterns.
		queue_op(OP_INSERT, 32'sh7FFF_FFFF);
		queue_op(OP_INSERT, 32'sh8000_0000);
		queue_op(OP_INSERT, '0);
		queue_op(OP_INSERT, -1);
		// Fill to capacity with duplicates, then push one more into the full store.
		repeat (STORE_DEPTH - 4)
			queue_op(OP_INSERT, 32'sd7);
		queue_op(OP_INSERT, 32'sd3);
		// Delete an absent value, then a value with many copies.
		queue_op(OP_DELETE, 32'sd99);
		queue_op(OP_DELETE, 32'sd7);
		// Drain to empty, head first.
		queue_op(OP_DELETE, 32'sh8000_0000);
		queue_op(OP_DELETE, -1);
		queue_op(OP_DELETE, '0);
		queue_op(OP_DELETE, 32'sh7FFF_FFFF);
		live_vals.delete();

		// Random blocks: mostly fill-then-drain sequences over a small value pool.
		target = pending_ops.size() + RANDOM_ITEMS;
		while (pending_ops.size() < target) begin
			pool_size = $urandom_range(1, 5);
			for (int k = 0; k < pool_size; k++)
				value_pool[k] = $urandom_range(0, 1) ? $signed($urandom_range(0, 20)) - 10
					: $signed($urandom);
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				// Noise: arbitrary operations and values.
				repeat ($urandom_range(10, 30))
					queue_op($urandom_range(0, 1) ? OP_DELETE : OP_INSERT, $urandom);
			end else if (mode == 1) begin
				// Saturate an empty store with one value, usually overflow it, then wipe it out.
				queue_flush();
				repeat ($urandom_range(STORE_DEPTH, STORE_DEPTH + 4))
					queue_op(OP_INSERT, value_pool[0]);
				queue_op(OP_DELETE, value_pool[0]);
				live_vals.delete();
			end else begin
				repeat ($urandom_range(4, 22))
					queue_op(($urandom_range(0, 9) == 0) ? OP_DELETE : OP_INSERT, pick_value());
				repeat ($urandom_range(2, 12))
					queue_op(($urandom_range(0, 9) == 0) ? OP_INSERT : OP_DELETE, pick_value());
			end
			if ($urandom_range(0, 3) == 0)
				queue_flush();
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Hold until every item is taken and every result has come back.
		do
			@(posedge clk);
		while (pending_ops.size() != 0 || in_valid || expected_status.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_status.size() != 0) begin
			mismatches += expected_status.size();
			$display("%0d results never arrived", expected_status.size());
		end
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
